// ===== design/nmea_sentence_checker_unit_assert.svh =====
// ----------------------------------------------------------------------------
// NMEA sentence checker assertion macros
// Concurrent assertion helpers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECKER_UNIT_ASSERT_SVH
`define NMEA_SENTENCE_CHECKER_UNIT_ASSERT_SVH

// The property must hold in the same cycle as the condition.
`define NSC_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("nsc: same-cycle check failed");

// The property must hold in the cycle after the condition.
`define NSC_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("nsc: next-cycle check failed");

`endif

// ===== design/nsc_pkg.sv =====
// ----------------------------------------------------------------------------
// nsc_pkg
// Types and character constants shared by the NMEA sentence checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nsc_pkg;

  typedef enum logic [2:0] {
    KIND_UNKNOWN = 3'd0,
    KIND_GGA     = 3'd1,
    KIND_RMC     = 3'd2,
    KIND_VTG     = 3'd3,
    KIND_GSA     = 3'd4
  } kind_t;

  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_G      = 8'h47;
  localparam logic [7:0] CHAR_P      = 8'h50;
  localparam logic [7:0] CHAR_N      = 8'h4E;
  localparam logic [7:0] CHAR_R      = 8'h52;
  localparam logic [7:0] CHAR_V      = 8'h56;
  localparam logic [7:0] CHAR_S      = 8'h53;
  localparam logic [7:0] CHAR_M      = 8'h4D;
  localparam logic [7:0] CHAR_T      = 8'h54;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_C      = 8'h43;

  localparam logic [5:0] GGA_MIN_FIELDS = 6'd10;
  localparam logic [5:0] RMC_MIN_FIELDS = 6'd12;
  localparam logic [5:0] VTG_MIN_FIELDS = 6'd9;
  localparam logic [5:0] GSA_MIN_FIELDS = 6'd18;

  localparam logic [6:0] HEADER_LEN   = 7'd6;
  localparam logic [6:0] POSITION_MAX = 7'd127;
  localparam logic [5:0] COMMA_MAX    = 6'd63;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } item_t;

  typedef struct packed {
    kind_t      kind;
    logic       checksum_ok;
    logic       accepted;
    logic       fix_valid;
    logic [3:0] fix_quality;
    logic [5:0] field_count;
  } result_t;

endpackage

`default_nettype wire

// ===== design/nsc_input_stage.sv =====
// ----------------------------------------------------------------------------
// nsc_input_stage
// Input register for one sentence byte and its end flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nsc_input_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [7:0]    rx_byte,
  input  wire logic          end_of_sentence,
  input  wire logic          advance,
  output logic               in_stall,
  output logic               item_valid,
  output nsc_pkg::item_t     item
);
  import nsc_pkg::*;

  // The held byte blocks new requests only when it cannot move on.
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item.data <= rx_byte;
      item.eos  <= end_of_sentence;
    end
  end

endmodule

`default_nettype wire

// ===== design/nsc_sentence_state.sv =====
// ----------------------------------------------------------------------------
// nsc_sentence_state
// Running sentence state and the verdict formed on the final byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nsc_sentence_state (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire nsc_pkg::item_t item,
  output nsc_pkg::result_t   result
);
  import nsc_pkg::*;

  logic [6:0] byte_position, byte_position_next;
  logic [7:0] xor_sum, xor_sum_next;
  logic       star_seen, star_seen_next;
  logic [1:0] after_star_count, after_star_count_next;
  logic [7:0] expected_hex, expected_hex_next;
  logic       hex_bad, hex_bad_next;
  kind_t      header_kind, header_kind_next;
  logic       header_live, header_live_next;
  logic [5:0] comma_count, comma_count_next;
  logic       last_was_comma, last_was_comma_next;
  logic [5:0] nonempty_fields, nonempty_fields_next;
  logic [3:0] quality_digit, quality_digit_next;
  logic [7:0] status_char, status_char_next;

  // Updated state after this byte, before any end-of-sentence clear.
  always_comb begin
    logic [7:0] b;
    logic       ok;
    logic [3:0] nibble;
    b = item.data;
    ok = header_live;
    nibble = 4'd0;

    byte_position_next    = byte_position;
    xor_sum_next          = xor_sum;
    star_seen_next        = star_seen;
    after_star_count_next = after_star_count;
    expected_hex_next     = expected_hex;
    hex_bad_next          = hex_bad;
    header_kind_next      = header_kind;
    header_live_next      = header_live;
    comma_count_next      = comma_count;
    last_was_comma_next   = last_was_comma;
    nonempty_fields_next  = nonempty_fields;
    quality_digit_next    = quality_digit;
    status_char_next      = status_char;

    if (!star_seen) begin
      if (b == CHAR_STAR) begin
        star_seen_next = 1'b1;
      end else begin
        if (b != CHAR_DOLLAR) begin
          xor_sum_next = xor_sum ^ b;
        end
        if (byte_position < HEADER_LEN) begin
          unique case (byte_position[2:0])
            3'd0: ok = ok && (b == CHAR_DOLLAR);
            3'd1: ok = ok && (b == CHAR_G);
            3'd2: ok = ok && ((b == CHAR_P) || (b == CHAR_N));
            3'd3: begin
              if (b == CHAR_G) header_kind_next = KIND_GGA;
              else if (b == CHAR_R) header_kind_next = KIND_RMC;
              else if (b == CHAR_V) header_kind_next = KIND_VTG;
              else ok = 1'b0;
            end
            3'd4: begin
              if (header_kind == KIND_GGA && b == CHAR_S) header_kind_next = KIND_GSA;
              else if (header_kind == KIND_GGA && b == CHAR_G) ok = ok;
              else if (header_kind == KIND_RMC && b == CHAR_M) ok = ok;
              else if (header_kind == KIND_VTG && b == CHAR_T) ok = ok;
              else ok = 1'b0;
            end
            3'd5: begin
              if (header_kind == KIND_GGA || header_kind == KIND_GSA) ok = ok && (b == CHAR_A);
              else if (header_kind == KIND_RMC) ok = ok && (b == CHAR_C);
              else if (header_kind == KIND_VTG) ok = ok && (b == CHAR_G);
              else ok = 1'b0;
            end
            default: ok = ok;
          endcase
          if (!ok) begin
            header_live_next = 1'b0;
            header_kind_next = KIND_UNKNOWN;
          end
        end
        if (b == CHAR_COMMA) begin
          if (comma_count < COMMA_MAX) begin
            comma_count_next = comma_count + 6'd1;
          end
          last_was_comma_next = 1'b1;
        end else begin
          for (int i = 0; i < 6; i++) begin
            if (comma_count == 6'(i + 1)) begin
              nonempty_fields_next[i] = 1'b1;
            end
          end
          if (last_was_comma) begin
            // First byte of a field: status is field 2, quality field 6.
            if (comma_count == 6'd2) begin
              status_char_next = b;
            end
            if (comma_count == 6'd6) begin
              quality_digit_next = (b >= 8'h30 && b <= 8'h39) ? b[3:0] : 4'd0;
            end
          end
          last_was_comma_next = 1'b0;
        end
        if (byte_position < POSITION_MAX) begin
          byte_position_next = byte_position + 7'd1;
        end
      end
    end else if (after_star_count < 2'd2) begin
      if (b >= 8'h30 && b <= 8'h39) begin
        nibble = b[3:0];
      end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
        nibble = b[3:0] + 4'd9;
      end else begin
        hex_bad_next = 1'b1;
      end
      expected_hex_next     = {expected_hex[3:0], nibble};
      after_star_count_next = after_star_count + 2'd1;
    end
  end

  // Verdict from the updated state.
  always_comb begin
    kind_t      kind;
    logic       ck;
    logic [6:0] count_wide;
    logic [5:0] count;
    logic       acc;
    kind = (header_live_next && byte_position_next >= HEADER_LEN) ?
           header_kind_next : KIND_UNKNOWN;
    ck = star_seen_next && (after_star_count_next == 2'd2) && !hex_bad_next &&
         (expected_hex_next == xor_sum_next);
    count_wide = {1'b0, comma_count_next} +
                 7'((byte_position_next != 7'd0) && !last_was_comma_next);
    count = count_wide[6] ? COMMA_MAX : count_wide[5:0];
    case (kind)
      KIND_GGA: acc = (count >= GGA_MIN_FIELDS) && (nonempty_fields_next[4:0] == 5'h1F);
      KIND_RMC: acc = (count >= RMC_MIN_FIELDS) && (nonempty_fields_next == 6'h3F);
      KIND_VTG: acc = (count >= VTG_MIN_FIELDS);
      KIND_GSA: acc = (count >= GSA_MIN_FIELDS);
      default:  acc = 1'b0;
    endcase
    acc = acc && ck;

    result.kind        = kind;
    result.checksum_ok = ck;
    result.accepted    = acc;
    result.field_count = count;
    result.fix_quality = (acc && kind == KIND_GGA) ? quality_digit_next : 4'd0;
    result.fix_valid   = acc && ((kind == KIND_GGA && quality_digit_next != 4'd0) ||
                                 (kind == KIND_RMC && status_char_next == CHAR_A));
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.eos)) begin
      byte_position    <= 7'd0;
      xor_sum          <= 8'd0;
      star_seen        <= 1'b0;
      after_star_count <= 2'd0;
      expected_hex     <= 8'd0;
      hex_bad          <= 1'b0;
      header_kind      <= KIND_UNKNOWN;
      header_live      <= 1'b1;
      comma_count      <= 6'd0;
      last_was_comma   <= 1'b0;
      nonempty_fields  <= 6'd0;
      quality_digit    <= 4'd0;
      status_char      <= CHAR_V;
    end else if (step) begin
      byte_position    <= byte_position_next;
      xor_sum          <= xor_sum_next;
      star_seen        <= star_seen_next;
      after_star_count <= after_star_count_next;
      expected_hex     <= expected_hex_next;
      hex_bad          <= hex_bad_next;
      header_kind      <= header_kind_next;
      header_live      <= header_live_next;
      comma_count      <= comma_count_next;
      last_was_comma   <= last_was_comma_next;
      nonempty_fields  <= nonempty_fields_next;
      quality_digit    <= quality_digit_next;
      status_char      <= status_char_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/nsc_result_reg.sv =====
// ----------------------------------------------------------------------------
// nsc_result_reg
// Output register that holds one sentence verdict until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nsc_result_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire nsc_pkg::result_t result,
  input  wire logic             out_stall,
  output logic                  out_free,
  output logic                  out_valid,
  output nsc_pkg::result_t      held
);
  import nsc_pkg::*;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

`default_nettype wire

// ===== design/nmea_sentence_checker_unit.sv =====
// ----------------------------------------------------------------------------
// nmea_sentence_checker_unit
// Byte-serial NMEA 0183 sentence checker: checksum, header, field rules.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------
//  input    | in_valid / in_stall   | rx_byte, end_of_sentence
//  result   | out_valid / out_stall | sentence_kind, checksum_ok, accepted,
//           |                       | fix_valid, fix_quality, field_count
//
// One byte is taken per cycle unless in_stall holds it; the running state
// updates as a byte leaves the input register.
// A verdict is loaded into the output register as its final byte leaves the input register.
// Reset clears the valid flags and the running sentence state; there is no clearing sweep.
// Bytes that end no sentence keep flowing while a verdict waits; only a final
// byte meeting a full, stalled output register holds the input.
`timescale 1ns / 1ps
`default_nettype none
`include "nmea_sentence_checker_unit_assert.svh"

module nmea_sentence_checker_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  input  wire logic       end_of_sentence,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      sentence_kind,
  output logic            checksum_ok,
  output logic            accepted,
  output logic            fix_valid,
  output logic [3:0]      fix_quality,
  output logic [5:0]      field_count
);
  import nsc_pkg::*;

  logic    item_valid;
  item_t   item;
  logic    out_free;
  logic    advance;
  logic    step;
  logic    emit;
  result_t result;
  result_t held;

  assign advance = !item_valid || !item.eos || out_free;
  assign step    = item_valid && advance;
  assign emit    = step && item.eos;

  nsc_input_stage u_input (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .rx_byte         (rx_byte),
    .end_of_sentence (end_of_sentence),
    .advance         (advance),
    .in_stall        (in_stall),
    .item_valid      (item_valid),
    .item            (item)
  );

  nsc_sentence_state u_state (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .result (result)
  );

  nsc_result_reg u_result (
    .clk       (clk),
    .rst       (rst),
    .load      (emit),
    .result    (result),
    .out_stall (out_stall),
    .out_free  (out_free),
    .out_valid (out_valid),
    .held      (held)
  );

  assign sentence_kind = held.kind;
  assign checksum_ok   = held.checksum_ok;
  assign accepted      = held.accepted;
  assign fix_valid     = held.fix_valid;
  assign fix_quality   = held.fix_quality;
  assign field_count   = held.field_count;

  `NSC_ASSERT_IMP(a_accept_needs_checksum, out_valid && accepted, checksum_ok && (sentence_kind != KIND_UNKNOWN))
  `NSC_ASSERT_IMP(a_fix_needs_accept, out_valid && (fix_valid || fix_quality != 4'd0), accepted)
  `NSC_ASSERT_IMP(a_stall_only_when_full, in_stall, out_valid && out_stall)
  `NSC_ASSERT_NXT(a_emit_shows_result, emit, out_valid)

endmodule

`default_nettype wire
